### rtl/core/md5bc_pkg.sv
// MD5 block compression: shared types, constants and round tables.
// Used by md5bc_ctrl, md5bc_dp and md5_block_compress_top; no dependencies.
`timescale 1ns / 1ps
`default_nettype none

package md5bc_pkg;

  localparam int unsigned WordW   = 32;
  localparam int unsigned NumWords = 16;
  localparam int unsigned WidxW   = 4;
  localparam int unsigned RidxW   = 6;

  localparam logic [WordW-1:0] InitA = 32'h67452301;
  localparam logic [WordW-1:0] InitB = 32'hefcdab89;
  localparam logic [WordW-1:0] InitC = 32'h98badcfe;
  localparam logic [WordW-1:0] InitD = 32'h10325476;

  localparam logic [1:0] PhaseF = 2'd0;
  localparam logic [1:0] PhaseG = 2'd1;
  localparam logic [1:0] PhaseH = 2'd2;
  localparam logic [1:0] PhaseI = 2'd3;

  localparam logic [RidxW-1:0] LastRound = 6'd63;
  localparam logic [WidxW-1:0] LastWord  = 4'd15;

  typedef struct packed {
    logic             buf_we;
    logic [WidxW-1:0] buf_idx;
    logic             reload;
    logic             prep;
    logic             round_en;
    logic [RidxW-1:0] rnd_idx;
    logic [RidxW-1:0] kw_idx;
    logic             finish;
  } dp_cmd_t;

  function automatic logic [WordW-1:0] sine_k(input logic [RidxW-1:0] r);
    logic [WordW-1:0] k;
    unique case (r)
      6'd0:  k = 32'hd76aa478;  6'd1:  k = 32'he8c7b756;
      6'd2:  k = 32'h242070db;  6'd3:  k = 32'hc1bdceee;
      6'd4:  k = 32'hf57c0faf;  6'd5:  k = 32'h4787c62a;
      6'd6:  k = 32'ha8304613;  6'd7:  k = 32'hfd469501;
      6'd8:  k = 32'h698098d8;  6'd9:  k = 32'h8b44f7af;
      6'd10: k = 32'hffff5bb1;  6'd11: k = 32'h895cd7be;
      6'd12: k = 32'h6b901122;  6'd13: k = 32'hfd987193;
      6'd14: k = 32'ha679438e;  6'd15: k = 32'h49b40821;
      6'd16: k = 32'hf61e2562;  6'd17: k = 32'hc040b340;
      6'd18: k = 32'h265e5a51;  6'd19: k = 32'he9b6c7aa;
      6'd20: k = 32'hd62f105d;  6'd21: k = 32'h02441453;
      6'd22: k = 32'hd8a1e681;  6'd23: k = 32'he7d3fbc8;
      6'd24: k = 32'h21e1cde6;  6'd25: k = 32'hc33707d6;
      6'd26: k = 32'hf4d50d87;  6'd27: k = 32'h455a14ed;
      6'd28: k = 32'ha9e3e905;  6'd29: k = 32'hfcefa3f8;
      6'd30: k = 32'h676f02d9;  6'd31: k = 32'h8d2a4c8a;
      6'd32: k = 32'hfffa3942;  6'd33: k = 32'h8771f681;
      6'd34: k = 32'h6d9d6122;  6'd35: k = 32'hfde5380c;
      6'd36: k = 32'ha4beea44;  6'd37: k = 32'h4bdecfa9;
      6'd38: k = 32'hf6bb4b60;  6'd39: k = 32'hbebfbc70;
      6'd40: k = 32'h289b7ec6;  6'd41: k = 32'heaa127fa;
      6'd42: k = 32'hd4ef3085;  6'd43: k = 32'h04881d05;
      6'd44: k = 32'hd9d4d039;  6'd45: k = 32'he6db99e5;
      6'd46: k = 32'h1fa27cf8;  6'd47: k = 32'hc4ac5665;
      6'd48: k = 32'hf4292244;  6'd49: k = 32'h432aff97;
      6'd50: k = 32'hab9423a7;  6'd51: k = 32'hfc93a039;
      6'd52: k = 32'h655b59c3;  6'd53: k = 32'h8f0ccc92;
      6'd54: k = 32'hffeff47d;  6'd55: k = 32'h85845dd1;
      6'd56: k = 32'h6fa87e4f;  6'd57: k = 32'hfe2ce6e0;
      6'd58: k = 32'ha3014314;  6'd59: k = 32'h4e0811a1;
      6'd60: k = 32'hf7537e82;  6'd61: k = 32'hbd3af235;
      6'd62: k = 32'h2ad7d2bb;  6'd63: k = 32'heb86d391;
      default: k = '0;
    endcase
    return k;
  endfunction

  function automatic logic [WidxW-1:0] msg_index(input logic [RidxW-1:0] r);
    logic [WidxW-1:0] n;
    logic [WidxW-1:0] g;
    n = r[WidxW-1:0];
    unique case (r[RidxW-1:RidxW-2])
      PhaseF:  g = n;
      PhaseG:  g = WidxW'(n * 4'd5 + 4'd1);
      PhaseH:  g = WidxW'(n * 4'd3 + 4'd5);
      PhaseI:  g = WidxW'(n * 4'd7);
      default: g = n;
    endcase
    return g;
  endfunction

  function automatic logic [4:0] rot_amt(input logic [RidxW-1:0] r);
    logic [4:0] s;
    unique case ({r[RidxW-1:RidxW-2], r[1:0]})
      4'd0:  s = 5'd7;   4'd1:  s = 5'd12;  4'd2:  s = 5'd17;  4'd3:  s = 5'd22;
      4'd4:  s = 5'd5;   4'd5:  s = 5'd9;   4'd6:  s = 5'd14;  4'd7:  s = 5'd20;
      4'd8:  s = 5'd4;   4'd9:  s = 5'd11;  4'd10: s = 5'd16;  4'd11: s = 5'd23;
      4'd12: s = 5'd6;   4'd13: s = 5'd10;  4'd14: s = 5'd15;  4'd15: s = 5'd21;
      default: s = 5'd0;
    endcase
    return s;
  endfunction

  function automatic logic [WordW-1:0] rotl(input logic [WordW-1:0] x,
                                            input logic [4:0] s);
    logic [2*WordW-1:0] t;
    t = {x, x} << s;
    return t[2*WordW-1:WordW];
  endfunction

endpackage

`default_nettype wire

### rtl/core/md5bc_if.sv
// Valid/ready channel interfaces for the MD5 block compression core.
// Standalone; carries message words in and digest words out.
`timescale 1ns / 1ps
`default_nettype none

interface md5bc_in_if;
  logic        valid;
  logic        ready;
  logic [31:0] msg_word;
  logic        new_message;

  modport source (output valid, output msg_word, output new_message, input ready);
  modport sink   (input valid, input msg_word, input new_message, output ready);
endinterface

interface md5bc_out_if;
  logic        valid;
  logic        ready;
  logic [31:0] digest_a;
  logic [31:0] digest_b;
  logic [31:0] digest_c;
  logic [31:0] digest_d;

  modport source (output valid, output digest_a, output digest_b,
                  output digest_c, output digest_d, input ready);
  modport sink   (input valid, input digest_a, input digest_b,
                  input digest_c, input digest_d, output ready);
endinterface

`default_nettype wire

### rtl/core/md5bc_ctrl.sv
// MD5 block compression controller: word counter, round counter, state machine.
// Depends on md5bc_pkg; drives md5bc_dp through md5bc_pkg::dp_cmd_t.
`timescale 1ns / 1ps
`default_nettype none

module md5bc_ctrl (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              in_valid_i,
  input  wire logic              in_new_message_i,
  output logic                   in_ready_o,
  output logic                   out_valid_o,
  input  wire logic              out_ready_i,
  output md5bc_pkg::dp_cmd_t     cmd_o
);

  localparam logic [1:0] StIdle  = 2'd0;
  localparam logic [1:0] StPrep  = 2'd1;
  localparam logic [1:0] StRound = 2'd2;
  localparam logic [1:0] StDone  = 2'd3;

  logic [1:0]                    state_q, state_d;
  logic [md5bc_pkg::WidxW-1:0]   count_q, count_d;
  logic [md5bc_pkg::RidxW-1:0]   round_q, round_d;
  logic                          out_valid_q, out_valid_d;
  logic                          in_xfer;
  logic [md5bc_pkg::WidxW-1:0]   widx;

  // hold off the last word of a block while a previous digest is still pending
  assign in_ready_o = (state_q == StIdle) &&
                      !(out_valid_q && !out_ready_i && count_q == md5bc_pkg::LastWord);
  assign in_xfer    = in_valid_i && in_ready_o;
  assign widx       = in_new_message_i ? '0 : count_q;
  assign out_valid_o = out_valid_q;

  always_comb begin
    state_d     = state_q;
    count_d     = count_q;
    round_d     = round_q;
    out_valid_d = out_valid_q && !out_ready_i;

    cmd_o          = '0;
    cmd_o.buf_idx  = widx;
    cmd_o.rnd_idx  = round_q;
    cmd_o.kw_idx   = md5bc_pkg::RidxW'(round_q + 1'b1);

    unique case (state_q)
      StIdle: begin
        if (in_xfer) begin
          cmd_o.buf_we = 1'b1;
          cmd_o.reload = in_new_message_i;
          count_d      = md5bc_pkg::WidxW'(widx + 1'b1);
          if (widx == md5bc_pkg::LastWord) begin
            state_d = StPrep;
          end
        end
      end
      StPrep: begin
        cmd_o.prep   = 1'b1;
        cmd_o.kw_idx = '0;
        round_d      = '0;
        state_d      = StRound;
      end
      StRound: begin
        cmd_o.round_en = 1'b1;
        round_d        = md5bc_pkg::RidxW'(round_q + 1'b1);
        if (round_q == md5bc_pkg::LastRound) begin
          state_d = StDone;
        end
      end
      StDone: begin
        cmd_o.finish = 1'b1;
        out_valid_d  = 1'b1;
        state_d      = StIdle;
      end
      default: state_d = StIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= StIdle;
      count_q     <= '0;
      round_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      count_q     <= count_d;
      round_q     <= round_d;
      out_valid_q <= out_valid_d;
    end
  end

endmodule

`default_nettype wire

### rtl/core/md5bc_dp.sv
// MD5 block compression datapath: block buffer, chaining words, round unit.
// Depends on md5bc_pkg; commanded by md5bc_ctrl.
`timescale 1ns / 1ps
`default_nettype none

module md5bc_dp (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire md5bc_pkg::dp_cmd_t cmd_i,
  input  wire logic [31:0]        msg_word_i,
  output logic [31:0]             digest_a_o,
  output logic [31:0]             digest_b_o,
  output logic [31:0]             digest_c_o,
  output logic [31:0]             digest_d_o
);

  localparam int unsigned W = md5bc_pkg::WordW;

  logic [W-1:0] buf_q [md5bc_pkg::NumWords];
  logic [W-1:0] ca_q, cb_q, cc_q, cd_q;
  logic [W-1:0] ca_d, cb_d, cc_d, cd_d;
  logic [W-1:0] a_q, b_q, c_q, d_q;
  logic [W-1:0] a_d, b_d, c_d, d_d;
  logic [W-1:0] kw_q, kw_d;
  logic [W-1:0] da_q, db_q, dc_q, dd_q;
  logic [W-1:0] f, sum;
  logic [W-1:0] sa, sb, sc, sd;

  always_ff @(posedge clk_i) begin
    if (cmd_i.buf_we) begin
      buf_q[cmd_i.buf_idx] <= msg_word_i;
    end
  end

  // K + M for the next round, registered in the cycle before that round uses it
  assign kw_d = md5bc_pkg::sine_k(cmd_i.kw_idx) + buf_q[md5bc_pkg::msg_index(cmd_i.kw_idx)];

  always_comb begin
    unique case (cmd_i.rnd_idx[md5bc_pkg::RidxW-1:md5bc_pkg::RidxW-2])
      md5bc_pkg::PhaseF: f = (b_q & c_q) | (~b_q & d_q);
      md5bc_pkg::PhaseG: f = (b_q & d_q) | (c_q & ~d_q);
      md5bc_pkg::PhaseH: f = b_q ^ c_q ^ d_q;
      md5bc_pkg::PhaseI: f = c_q ^ (b_q | ~d_q);
      default:           f = '0;
    endcase
  end

  assign sum = f + a_q + kw_q;

  assign sa = ca_q + a_q;
  assign sb = cb_q + b_q;
  assign sc = cc_q + c_q;
  assign sd = cd_q + d_q;

  always_comb begin
    a_d = a_q;
    b_d = b_q;
    c_d = c_q;
    d_d = d_q;
    if (cmd_i.prep) begin
      a_d = ca_q;
      b_d = cb_q;
      c_d = cc_q;
      d_d = cd_q;
    end else if (cmd_i.round_en) begin
      a_d = d_q;
      d_d = c_q;
      c_d = b_q;
      b_d = b_q + md5bc_pkg::rotl(sum, md5bc_pkg::rot_amt(cmd_i.rnd_idx));
    end
  end

  always_comb begin
    ca_d = ca_q;
    cb_d = cb_q;
    cc_d = cc_q;
    cd_d = cd_q;
    priority if (cmd_i.reload) begin
      ca_d = md5bc_pkg::InitA;
      cb_d = md5bc_pkg::InitB;
      cc_d = md5bc_pkg::InitC;
      cd_d = md5bc_pkg::InitD;
    end else if (cmd_i.finish) begin
      ca_d = sa;
      cb_d = sb;
      cc_d = sc;
      cd_d = sd;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ca_q <= md5bc_pkg::InitA;
      cb_q <= md5bc_pkg::InitB;
      cc_q <= md5bc_pkg::InitC;
      cd_q <= md5bc_pkg::InitD;
      a_q  <= '0;
      b_q  <= '0;
      c_q  <= '0;
      d_q  <= '0;
    end else begin
      ca_q <= ca_d;
      cb_q <= cb_d;
      cc_q <= cc_d;
      cd_q <= cd_d;
      a_q  <= a_d;
      b_q  <= b_d;
      c_q  <= c_d;
      d_q  <= d_d;
    end
  end

  always_ff @(posedge clk_i) begin
    kw_q <= kw_d;
    if (cmd_i.finish) begin
      da_q <= sa;
      db_q <= sb;
      dc_q <= sc;
      dd_q <= sd;
    end
  end

  assign digest_a_o = da_q;
  assign digest_b_o = db_q;
  assign digest_c_o = dc_q;
  assign digest_d_o = dd_q;

endmodule

`default_nettype wire

### rtl/core/md5_block_compress_top.sv
// MD5 block compression top: one 32-bit word per transfer in, digest out.
// Words of a block are accepted while the core is idle; after the 16th word's transfer
// the digest is formed by 1 setup step, 64 rounds at one per cycle and 1 final add.
// The single round unit serves one block at a time; no words are taken until it is idle.
// Reset (async, active low) loads the MD5 initial chaining words, clears counters.
// Depends on md5bc_pkg, md5bc_if, md5bc_ctrl and md5bc_dp.
`timescale 1ns / 1ps
`default_nettype none

module md5_block_compress_top (
  input  wire logic  clk_i,
  input  wire logic  rst_ni,
  md5bc_in_if.sink   in_i,
  md5bc_out_if.source out_o
);

  md5bc_pkg::dp_cmd_t cmd;

  md5bc_ctrl u_ctrl (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .in_valid_i       (in_i.valid),
    .in_new_message_i (in_i.new_message),
    .in_ready_o       (in_i.ready),
    .out_valid_o      (out_o.valid),
    .out_ready_i      (out_o.ready),
    .cmd_o            (cmd)
  );

  md5bc_dp u_dp (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cmd_i      (cmd),
    .msg_word_i (in_i.msg_word),
    .digest_a_o (out_o.digest_a),
    .digest_b_o (out_o.digest_b),
    .digest_c_o (out_o.digest_c),
    .digest_d_o (out_o.digest_d)
  );

endmodule

`default_nettype wire

### sim/tb_md5_block_compress_top.sv
// Self-checking testbench for md5_block_compress_top: message words in, digests out.
// Drives directed and random word streams and checks each digest against an MD5 predictor.
// Depends on md5bc_pkg, md5bc_if and the md5_block_compress_top RTL.
`timescale 1ns / 1ps

module tb_md5_block_compress_top;

  typedef struct packed {
    logic [31:0] a;
    logic [31:0] b;
    logic [31:0] c;
    logic [31:0] d;
  } digest_t;

  typedef struct packed {
    logic [31:0] word;
    logic        first;
    logic        typed;
    digest_t     digest;
  } stim_row_t;

  localparam int unsigned NumItems    = 550;
  localparam int unsigned QuietItems  = 60;
  localparam int unsigned DrainCycles = 200;
  localparam int unsigned CycleLimit  = 400000;

  localparam digest_t NoDigest  = '0;
  localparam digest_t AbcDigest = {32'h98500190, 32'hb04fd23c, 32'h7d3f96d6, 32'h727fe128};

  localparam logic [31:0] SineK [64] = '{
    32'hd76aa478, 32'he8c7b756, 32'h242070db, 32'hc1bdceee,
    32'hf57c0faf, 32'h4787c62a, 32'ha8304613, 32'hfd469501,
    32'h698098d8, 32'h8b44f7af, 32'hffff5bb1, 32'h895cd7be,
    32'h6b901122, 32'hfd987193, 32'ha679438e, 32'h49b40821,
    32'hf61e2562, 32'hc040b340, 32'h265e5a51, 32'he9b6c7aa,
    32'hd62f105d, 32'h02441453, 32'hd8a1e681, 32'he7d3fbc8,
    32'h21e1cde6, 32'hc33707d6, 32'hf4d50d87, 32'h455a14ed,
    32'ha9e3e905, 32'hfcefa3f8, 32'h676f02d9, 32'h8d2a4c8a,
    32'hfffa3942, 32'h8771f681, 32'h6d9d6122, 32'hfde5380c,
    32'ha4beea44, 32'h4bdecfa9, 32'hf6bb4b60, 32'hbebfbc70,
    32'h289b7ec6, 32'heaa127fa, 32'hd4ef3085, 32'h04881d05,
    32'hd9d4d039, 32'he6db99e5, 32'h1fa27cf8, 32'hc4ac5665,
    32'hf4292244, 32'h432aff97, 32'hab9423a7, 32'hfc93a039,
    32'h655b59c3, 32'h8f0ccc92, 32'hffeff47d, 32'h85845dd1,
    32'h6fa87e4f, 32'hfe2ce6e0, 32'ha3014314, 32'h4e0811a1,
    32'hf7537e82, 32'hbd3af235, 32'h2ad7d2bb, 32'heb86d391
  };

  localparam int RotS [16] = '{7, 12, 17, 22, 5, 9, 14, 20, 4, 11, 16, 23, 6, 10, 15, 21};

  // Words before any start flag, two restarts mid-block, then the padded "abc" block.
  localparam stim_row_t DirRows [20] = '{
    {32'hffffffff, 1'b0, 1'b0, NoDigest},
    {32'h00000000, 1'b0, 1'b0, NoDigest},
    {32'hffffffff, 1'b1, 1'b0, NoDigest},
    {32'h12345678, 1'b0, 1'b0, NoDigest},
    {32'h80636261, 1'b1, 1'b0, NoDigest},
    {32'h00000000, 1'b0, 1'b0, NoDigest},
    {32'h00000000, 1'b0, 1'b0, NoDigest},
    {32'h00000000, 1'b0, 1'b0, NoDigest},
    {32'h00000000, 1'b0, 1'b0, NoDigest},
    {32'h00000000, 1'b0, 1'b0, NoDigest},
    {32'h00000000, 1'b0, 1'b0, NoDigest},
    {32'h00000000, 1'b0, 1'b0, NoDigest},
    {32'h00000000, 1'b0, 1'b0, NoDigest},
    {32'h00000000, 1'b0, 1'b0, NoDigest},
    {32'h00000000, 1'b0, 1'b0, NoDigest},
    {32'h00000000, 1'b0, 1'b0, NoDigest},
    {32'h00000000, 1'b0, 1'b0, NoDigest},
    {32'h00000000, 1'b0, 1'b0, NoDigest},
    {32'h00000018, 1'b0, 1'b0, NoDigest},
    {32'h00000000, 1'b0, 1'b1, AbcDigest}
  };

  logic clk_i;
  logic rst_ni;

  md5bc_in_if  msg_if ();
  md5bc_out_if dig_if ();

  md5_block_compress_top u_top (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (msg_if),
    .out_o  (dig_if)
  );

  digest_t       hash_chain = {md5bc_pkg::InitA, md5bc_pkg::InitB,
                               md5bc_pkg::InitC, md5bc_pkg::InitD};
  logic [31:0]   msg_block [16];
  logic [3:0]    word_pos = '0;
  digest_t       digest_q [$];

  int unsigned   items_sent = 0;
  int unsigned   mismatches = 0;
  int unsigned   cycle_count = 0;
  logic          quiet = 1'b0;
  logic          gaps_on = 1'b1;

  function automatic digest_t md5_compress(input digest_t h);
    logic [31:0] a, b, c, d, f, sum;
    int          g;
    int          s;
    a = h.a;
    b = h.b;
    c = h.c;
    d = h.d;
    for (int r = 0; r < 64; r++) begin
      case (r / 16)
        0: begin
          f = (b & c) | (~b & d);
          g = r;
        end
        1: begin
          f = (b & d) | (c & ~d);
          g = (5 * r + 1) % 16;
        end
        2: begin
          f = b ^ c ^ d;
          g = (3 * r + 5) % 16;
        end
        default: begin
          f = c ^ (b | ~d);
          g = (7 * r) % 16;
        end
      endcase
      s   = RotS[(r / 16) * 4 + r % 4];
      sum = a + f + SineK[r] + msg_block[g];
      a   = d;
      d   = c;
      c   = b;
      b   = b + ((sum << s) | (sum >> (32 - s)));
    end
    return {h.a + a, h.b + b, h.c + c, h.d + d};
  endfunction

  // Returns 1 when the word completes a block; digest holds the new chain.
  function automatic logic absorb_word(input logic [31:0] w, input logic first,
                                       output digest_t digest);
    digest = NoDigest;
    if (first) begin
      hash_chain = {md5bc_pkg::InitA, md5bc_pkg::InitB,
                    md5bc_pkg::InitC, md5bc_pkg::InitD};
      word_pos   = '0;
    end
    msg_block[word_pos] = w;
    word_pos = word_pos + 4'd1;
    if (word_pos != 4'd0) return 1'b0;
    hash_chain = md5_compress(hash_chain);
    digest     = hash_chain;
    return 1'b1;
  endfunction

  function automatic logic [31:0] pick_word();
    case ($urandom_range(0, 7))
      0:       return 32'h00000000;
      1:       return 32'hffffffff;
      2:       return 32'h1 << $urandom_range(0, 31);
      3:       return ~(32'h1 << $urandom_range(0, 31));
      default: return $urandom();
    endcase
  endfunction

  task automatic send_word(input logic [31:0] w, input logic first, input logic typed,
                           input digest_t typed_digest);
    digest_t digest;
    if (!quiet && gaps_on && $urandom_range(0, 4) == 0) begin
      msg_if.valid <= 1'b0;
      repeat ($urandom_range(1, 17)) @(posedge clk_i);
    end
    msg_if.valid       <= 1'b1;
    msg_if.msg_word    <= w;
    msg_if.new_message <= first;
    @(posedge clk_i);
    while (!msg_if.ready) @(posedge clk_i);
    if (absorb_word(w, first, digest)) begin
      digest_q.push_back(typed ? typed_digest : digest);
    end
    items_sent++;
    if (items_sent + QuietItems >= NumItems) quiet = 1'b1;
  endtask

  task automatic wait_for_digests();
    while (digest_q.size() != 0) @(posedge clk_i);
  endtask

  function automatic void check_field(input string name, input logic [31:0] want,
                                      input logic [31:0] got);
    if (got !== want) begin
      $error("%s: expected %h, got %h", name, want, got);
      mismatches++;
    end
  endfunction

  initial begin
    clk_i = 1'b0;
    forever #2 clk_i = ~clk_i;
  end

  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count > CycleLimit) begin
      $display("== FAIL ==");
      $finish;
    end
  end

  // Result side: bursts of backpressure, rate changes now and then.
  initial begin : ready_drive
    int unsigned stall_odds;
    dig_if.ready <= 1'b0;
    stall_odds = 8;
    forever begin
      @(posedge clk_i);
      if ($urandom_range(0, 199) == 0) stall_odds = $urandom_range(0, 3) * 8;
      if (!quiet && stall_odds != 0 && $urandom_range(1, stall_odds) == 1) begin
        dig_if.ready <= 1'b0;
        repeat ($urandom_range(1, 17)) @(posedge clk_i);
        dig_if.ready <= 1'b1;
      end else begin
        dig_if.ready <= 1'b1;
      end
    end
  end

  always @(posedge clk_i) begin : digest_check
    digest_t got;
    digest_t want;
    if (rst_ni && dig_if.valid && dig_if.ready) begin
      got = {dig_if.digest_a, dig_if.digest_b, dig_if.digest_c, dig_if.digest_d};
      if (digest_q.size() == 0) begin
        $error("unexpected digest transfer %h", got);
        mismatches++;
      end else begin
        want = digest_q.pop_front();
        check_field("digest_a", want.a, got.a);
        check_field("digest_b", want.b, got.b);
        check_field("digest_c", want.c, got.c);
        check_field("digest_d", want.d, got.d);
      end
    end
  end

  initial begin : stimulus
    int unsigned kind;
    int unsigned nblk;
    int unsigned nwords;
    msg_if.valid       <= 1'b0;
    msg_if.msg_word    <= '0;
    msg_if.new_message <= 1'b0;
    rst_ni             <= 1'b0;
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    for (int i = 0; i < 20; i++) begin
      send_word(DirRows[i].word, DirRows[i].first, DirRows[i].typed, DirRows[i].digest);
    end
    msg_if.valid <= 1'b0;
    wait_for_digests();

    while (items_sent < NumItems) begin
      gaps_on = $urandom_range(0, 3) != 0;
      kind    = $urandom_range(0, 99);
      if (kind < 75) begin
        nblk = $urandom_range(1, 3);
        for (int b = 0; b < nblk; b++) begin
          for (int i = 0; i < 16; i++) begin
            send_word(pick_word(), b == 0 && i == 0, 1'b0, NoDigest);
          end
        end
      end else if (kind < 85) begin
        // continuation block with no start flag
        for (int i = 0; i < 16; i++) send_word(pick_word(), 1'b0, 1'b0, NoDigest);
      end else begin
        // truncated block, start flags scattered
        nwords = $urandom_range(1, 15);
        for (int i = 0; i < nwords; i++) begin
          send_word(pick_word(), $urandom_range(0, 3) == 0, 1'b0, NoDigest);
        end
      end
      if (!quiet && $urandom_range(0, 9) == 0) begin
        msg_if.valid <= 1'b0;
        @(posedge clk_i);
        wait_for_digests();
      end
    end
    msg_if.valid <= 1'b0;

    wait_for_digests();
    repeat (DrainCycles) @(posedge clk_i);
    if (mismatches == 0 && digest_q.size() == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
